>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with a reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define ILST_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never shows at a rising edge outside reset.
`define ILST_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hdl/ilst_pkg.sv
// ---------------------------------------------------------------------------
// Ordered list package
// Request and status codes, controller states and the command/status
// structs that join the controller to the datapath.
// ---------------------------------------------------------------------------
package ilst_pkg;

  localparam int WORD_W = 32;
  localparam int REQ_W  = 3;
  localparam int STS_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_CLEAR  = 3'd2,
    REQ_SEARCH = 3'd3,
    REQ_VISIT  = 3'd4
  } req_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK      = 2'd0,
    STS_RANGE   = 2'd1,
    STS_FULL    = 2'd2,
    STS_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_REPORT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture the accepted word
    logic commit;      // apply a non-search request and write its result
    logic scan_start;  // reset the search pointer
    logic scan_step;   // compare one cell and advance
    logic report;      // write the search result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_search;
    logic list_empty;
    logic scan_hit;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> hdl/ilst_ctrl.sv
// ---------------------------------------------------------------------------
// Ordered list controller
// Sequences accept, execute, search scan and result write for one request
// at a time.
// ---------------------------------------------------------------------------
module ilst_ctrl
  import ilst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_search) begin
          cmd.scan_start = 1'b1;
          state_next     = sts.list_empty ? S_REPORT : S_SCAN;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit || sts.scan_last) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        if (sts.out_free) begin
          cmd.report = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/ilst_datapath.sv
// ---------------------------------------------------------------------------
// Ordered list datapath
// Row of element cells with parallel shift for insert and remove, one read
// port shared by visit and the search scan, and the result register.
// ---------------------------------------------------------------------------
module ilst_datapath
  import ilst_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  parameter int LW         = $clog2(CAPACITY + 1),
  parameter int IW         = $clog2(CAPACITY)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  output dp_status_t               sts,
  input  logic [REQ_W-1:0]         req_type,
  input  logic [LW-1:0]            position,
  input  logic signed [WORD_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STS_W-1:0]         status,
  output logic signed [WORD_W-1:0] data_out,
  output logic [IW-1:0]            index_out,
  output logic [LW-1:0]            list_length
);

  localparam int EXT_W = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  logic [DATA_WIDTH-1:0]  cells [CAPACITY];
  logic [REQ_W-1:0]       req_q;
  logic [LW-1:0]          pos_q;
  logic [DATA_WIDTH-1:0]  val_q;
  logic [LW-1:0]          count;
  logic [IW-1:0]          scan_idx;
  logic                   hit_q;

  logic [EXT_W-1:0]        val_ext;
  logic [IW-1:0]           rd_addr;
  logic [DATA_WIDTH-1:0]   rd_word;
  logic signed [EXT_W-1:0] rd_ext;
  logic                    scan_hit;
  logic                    scan_last;
  logic                    ins_en;
  logic                    rem_en;
  logic [STS_W-1:0]        sts_c;
  logic [LW-1:0]           count_next;
  logic [WORD_W-1:0]       data_c;

  // Store only the low bits of the incoming value
  assign val_ext = EXT_W'($unsigned(value));

  // Shared read port: scan pointer during search, position otherwise
  assign rd_addr   = (req_q == REQ_SEARCH) ? scan_idx : pos_q[IW-1:0];
  assign rd_word   = cells[rd_addr];
  assign rd_ext    = EXT_W'($signed(rd_word));
  assign scan_hit  = (rd_word == val_q);
  assign scan_last = (LW'(scan_idx) == (count - LW'(1)));

  assign sts.is_search  = (req_q == REQ_SEARCH);
  assign sts.list_empty = (count == '0);
  assign sts.scan_hit   = scan_hit;
  assign sts.scan_last  = scan_last;
  assign sts.out_free   = !out_valid || out_ready;

  // Decode the held request against the current length
  always_comb begin
    sts_c      = STS_OK;
    count_next = count;
    ins_en     = 1'b0;
    rem_en     = 1'b0;
    data_c     = '0;
    case (req_q)
      REQ_INSERT: begin
        if (pos_q > count) begin
          sts_c = STS_RANGE;
        end else if (count == CAP_L) begin
          sts_c = STS_FULL;
        end else begin
          ins_en     = 1'b1;
          count_next = count + LW'(1);
        end
      end
      REQ_REMOVE: begin
        if (pos_q >= count) begin
          sts_c = STS_RANGE;
        end else begin
          rem_en     = 1'b1;
          count_next = count - LW'(1);
        end
      end
      REQ_CLEAR: begin
        count_next = '0;
      end
      REQ_VISIT: begin
        if (pos_q >= count) begin
          sts_c = STS_RANGE;
        end else begin
          data_c = rd_ext[WORD_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Cell row: open a gap on insert, close it up on remove
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    localparam logic [LW-1:0] KL = LW'(k);
    logic [DATA_WIDTH-1:0] left_word;
    logic [DATA_WIDTH-1:0] right_word;

    if (k > 0) begin : g_left
      assign left_word = cells[k-1];
    end else begin : g_left0
      assign left_word = '0;
    end
    if (k < CAPACITY - 1) begin : g_right
      assign right_word = cells[k+1];
    end else begin : g_right_end
      assign right_word = '0;
    end

    always_ff @(posedge clk) begin
      if (cmd.commit && ins_en) begin
        if (KL == pos_q) begin
          cells[k] <= val_q;
        end else if (KL > pos_q && KL <= count) begin
          cells[k] <= left_word;
        end
      end else if (cmd.commit && rem_en) begin
        if (KL >= pos_q && (KL + LW'(1)) < count) begin
          cells[k] <= right_word;
        end
      end
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_type;
      pos_q <= position;
      val_q <= val_ext[DATA_WIDTH-1:0];
    end
  end

  // Length, search pointer and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      scan_idx  <= '0;
      hit_q     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count <= count_next;
      end
      if (cmd.scan_start) begin
        scan_idx <= '0;
        hit_q    <= 1'b0;
      end else if (cmd.scan_step) begin
        hit_q <= scan_hit;
        if (!scan_hit && !scan_last) begin
          scan_idx <= scan_idx + IW'(1);
        end
      end
      if (cmd.commit || cmd.report) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status      <= sts_c;
      data_out    <= data_c;
      index_out   <= '0;
      list_length <= count_next;
    end else if (cmd.report) begin
      status      <= hit_q ? STS_OK : STS_MISSING;
      data_out    <= '0;
      index_out   <= hit_q ? scan_idx : '0;
      list_length <= count;
    end
  end

endmodule

>>> hdl/indexed_ordered_list_core.sv
// Insert, remove, clear, visit: applied in the execute state once the output
// is free, result registered. Search: the single compare unit steps one cell
// per cycle over k cells (0 on an empty list, else 1 to length), then reports
// once the output is free. The next word is taken while a result waits.
// Synchronous reset empties the list, no clearing pass.
// ---------------------------------------------------------------------------
// Indexed ordered list core
// Bounded ordered list with insert, remove, clear, search and visit.
// ---------------------------------------------------------------------------
module indexed_ordered_list_core
  import ilst_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [REQ_W-1:0]                     req_type,
  input  logic [$clog2(CAPACITY+1)-1:0]        position,
  input  logic signed [WORD_W-1:0]             value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [STS_W-1:0]                     status,
  output logic signed [WORD_W-1:0]             data_out,
  output logic [$clog2(CAPACITY)-1:0]          index_out,
  output logic [$clog2(CAPACITY+1)-1:0]        list_length
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  dp_cmd_t    cmd;
  dp_status_t sts;

  ilst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ilst_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .LW         (LW),
    .IW         (IW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req_type),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .data_out    (data_out),
    .index_out   (index_out),
    .list_length (list_length)
  );

endmodule

>>> hdl/ilst_checker.sv
// ---------------------------------------------------------------------------
// Ordered list port checker
// Watches the core's ports for length, status and result consistency.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ilst_checker
  import ilst_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [STS_W-1:0]              status,
  input logic signed [WORD_W-1:0]      data_out,
  input logic [$clog2(CAPACITY)-1:0]   index_out,
  input logic [$clog2(CAPACITY+1)-1:0] list_length
);

  localparam int LW = $clog2(CAPACITY + 1);

  // Reported length never passes the capacity
  `ILST_NEVER(a_len_cap, clk, rst, out_valid && (list_length > LW'(CAPACITY)), "length over capacity")

  // A full report comes only with a full list
  `ILST_ASSERT(a_full_len, clk, rst, out_valid && (status == STS_FULL) |-> list_length == LW'(CAPACITY), "full status with room left")

  // Any failure carries zero data and index
  `ILST_ASSERT(a_fail_zero, clk, rst, out_valid && (status != STS_OK) |-> (data_out == '0) && (index_out == '0), "failed request with data")

  // A stalled result holds
  `ILST_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(list_length), "result dropped while stalled")

  // Block input for the cycle after a word is taken
  `ILST_ASSERT(a_ready_drop, clk, rst, in_valid && in_ready |=> !in_ready, "words taken back to back")

endmodule

bind indexed_ordered_list_core ilst_checker #(.CAPACITY(CAPACITY)) u_chk (.*);
